// File: rtl/iqccm_pkg.sv
// Shared types and constants of the I/Q channel combiner and IF mixer.
package iqccm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 21;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(1048575);
	localparam logic signed [SUM_W-1:0] SUM_MIN  = -SUM_W'(1048576);
	localparam logic signed [SUM_W-1:0] WIDE_LIM = SUM_W'(32760);
	localparam logic signed [SAMPLE_W-1:0] Q15_ONE = SAMPLE_W'(32767);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYTE_MODE = 2'd0,
		REG_STEP_COS  = 2'd1,
		REG_STEP_SIN  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] chan_i;
		logic signed [SAMPLE_W-1:0] chan_q;
		logic                       last_channel;
	} chan_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] wide_i;
		logic signed [SAMPLE_W-1:0] wide_q;
		logic signed [BYTE_W-1:0]   byte_sample;
		logic                       clip_i;
		logic                       clip_q;
	} result_t;

endpackage

// File: rtl/iqccm_stream_if.sv
// Valid/ready stream channel carrying one payload item per request.
interface iqccm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/iqccm_cfg_if.sv
// Register write channel with valid/ready, register index and write data.
interface iqccm_cfg_if
	import iqccm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/iq_channel_combiner_mixer.sv
// I/Q channel combiner with saturation and Q1.15 IF mixer, top level.
// An accepted last-channel request goes through stage 1, stage 2 and the output register.
// Throughput: one request per cycle unless results.ready stalls; the phasor rotation and the sum
// update each close their feedback loop in a register, the mix products pass two more stages.
// arst_n low clears sums, valid flags, byte mode and sine step; phasor and cosine step go to one.
// Register writes are taken in any cycle and are meant to happen while the block is idle.
module iq_channel_combiner_mixer
	import iqccm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	iqccm_stream_if.sink   samples,
	iqccm_stream_if.source results,
	iqccm_cfg_if.sink      cfg
);

	localparam int PROD_W = SUM_W + SAMPLE_W;   // one mix product
	localparam int FULL_W = PROD_W + 1;         // difference of two products
	localparam int RND_W  = FULL_W - 15;        // after dropping the Q.15 fraction
	localparam int ROT_W  = 2 * SAMPLE_W;       // one rotation product

	// Divide by 2^15 rounding half away from zero.
	function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [FULL_W-1:0] v);
		logic signed [FULL_W-1:0] t;
		begin
			t = v + (v[FULL_W-1] ? FULL_W'(16383) : FULL_W'(16384));
			return t[FULL_W-1:15];
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [RND_W-1:0] v);
		if (v > RND_W'(32767))
			return SAMPLE_W'(32767);
		else if (v < -RND_W'(32768))
			return -SAMPLE_W'(32768);
		else
			return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [BYTE_W-1:0] sat8(input logic signed [RND_W-1:0] v);
		if (v > RND_W'(127))
			return BYTE_W'(127);
		else if (v < -RND_W'(128))
			return -BYTE_W'(128);
		else
			return v[BYTE_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] acc_sat(input logic signed [SUM_W-1:0] s,
			input logic signed [SAMPLE_W-1:0] x);
		logic signed [SUM_W:0] t;
		begin
			t = (SUM_W+1)'(s) + (SUM_W+1)'(x);
			if (t > (SUM_W+1)'(SUM_MAX))
				return SUM_MAX;
			else if (t < (SUM_W+1)'(SUM_MIN))
				return SUM_MIN;
			else
				return t[SUM_W-1:0];
		end
	endfunction

	// Configuration registers
	logic                       byte_mode_q;
	logic signed [SAMPLE_W-1:0] step_cos_q;
	logic signed [SAMPLE_W-1:0] step_sin_q;

	// Accumulator and phasor state
	logic signed [SUM_W-1:0]    sum_i_q, sum_q_q;
	logic signed [SAMPLE_W-1:0] phasor_cos_q, phasor_sin_q;

	// Stage 1: closed sums with the phasor they mix with
	logic                       valid_s1;
	logic                       byte_s1;
	logic signed [SUM_W-1:0]    sum_i_s1, sum_q_s1;
	logic signed [SAMPLE_W-1:0] cos_s1, sin_s1;

	// Stage 2: mix products and the saturated wide result
	logic                       valid_s2;
	logic                       byte_s2;
	logic signed [PROD_W-1:0]   prod_i_s2, prod_q_s2;
	logic signed [SAMPLE_W-1:0] wide_i_s2, wide_q_s2;
	logic                       clip_i_s2, clip_q_s2;

	// Output register
	logic    res_valid_q;
	result_t res_q;

	logic                       acc, cfg_acc;
	logic                       out_free, s2_free, s1_free;
	logic signed [SUM_W-1:0]    new_sum_i, new_sum_q;
	logic signed [ROT_W-1:0]    rot_cc, rot_ss, rot_sc, rot_cs;
	logic signed [FULL_W-1:0]   rot_cos_full, rot_sin_full;
	logic signed [SAMPLE_W-1:0] rot_cos, rot_sin;
	logic signed [FULL_W-1:0]   mix_full;
	logic                       ovr_i_s1, ovr_q_s1;

	assign out_free = !res_valid_q || results.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;

	assign samples.ready = s1_free;
	assign cfg.ready     = 1'b1;
	assign acc     = samples.valid && samples.ready;
	assign cfg_acc = cfg.valid && cfg.ready;

	assign new_sum_i = acc_sat(sum_i_q, samples.data.chan_i);
	assign new_sum_q = acc_sat(sum_q_q, samples.data.chan_q);

	// Phasor rotation by the configured step, exact in Q2.30 before rounding.
	assign rot_cc = ROT_W'(phasor_cos_q) * ROT_W'(step_cos_q);
	assign rot_ss = ROT_W'(phasor_sin_q) * ROT_W'(step_sin_q);
	assign rot_sc = ROT_W'(phasor_sin_q) * ROT_W'(step_cos_q);
	assign rot_cs = ROT_W'(phasor_cos_q) * ROT_W'(step_sin_q);
	assign rot_cos_full = FULL_W'(rot_cc) - FULL_W'(rot_ss);
	assign rot_sin_full = FULL_W'(rot_sc) + FULL_W'(rot_cs);
	assign rot_cos = sat16(rnd_q15(rot_cos_full));
	assign rot_sin = sat16(rnd_q15(rot_sin_full));

	assign ovr_i_s1 = (sum_i_s1 > WIDE_LIM) || (sum_i_s1 < -WIDE_LIM);
	assign ovr_q_s1 = (sum_q_s1 > WIDE_LIM) || (sum_q_s1 < -WIDE_LIM);

	assign mix_full = FULL_W'(prod_i_s2) - FULL_W'(prod_q_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_mode_q <= 1'b0;
			step_cos_q  <= Q15_ONE;
			step_sin_q  <= '0;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_BYTE_MODE: byte_mode_q <= cfg.data[0];
				REG_STEP_COS:  step_cos_q  <= cfg.data;
				REG_STEP_SIN:  step_sin_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_i_q      <= '0;
			sum_q_q      <= '0;
			phasor_cos_q <= Q15_ONE;
			phasor_sin_q <= '0;
		end else if (acc) begin
			if (samples.data.last_channel) begin
				sum_i_q <= '0;
				sum_q_q <= '0;
				if (byte_mode_q) begin
					phasor_cos_q <= rot_cos;
					phasor_sin_q <= rot_sin;
				end
			end else begin
				sum_i_q <= new_sum_i;
				sum_q_q <= new_sum_q;
			end
		end
	end

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= acc && samples.data.last_channel;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (out_free)
				res_valid_q <= valid_s2;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (s1_free) begin
			sum_i_s1 <= new_sum_i;
			sum_q_s1 <= new_sum_q;
			byte_s1  <= byte_mode_q;
			cos_s1   <= phasor_cos_q;
			sin_s1   <= phasor_sin_q;
		end
		if (s2_free) begin
			byte_s2   <= byte_s1;
			prod_i_s2 <= PROD_W'(sum_i_s1) * PROD_W'(cos_s1);
			prod_q_s2 <= PROD_W'(sum_q_s1) * PROD_W'(sin_s1);
			clip_i_s2 <= ovr_i_s1 && !byte_s1;
			clip_q_s2 <= ovr_q_s1 && !byte_s1;
			if (byte_s1) begin
				wide_i_s2 <= '0;
				wide_q_s2 <= '0;
			end else begin
				wide_i_s2 <= (sum_i_s1 > WIDE_LIM) ? WIDE_LIM[SAMPLE_W-1:0] :
					(sum_i_s1 < -WIDE_LIM) ? SAMPLE_W'(-WIDE_LIM) : sum_i_s1[SAMPLE_W-1:0];
				wide_q_s2 <= (sum_q_s1 > WIDE_LIM) ? WIDE_LIM[SAMPLE_W-1:0] :
					(sum_q_s1 < -WIDE_LIM) ? SAMPLE_W'(-WIDE_LIM) : sum_q_s1[SAMPLE_W-1:0];
			end
		end
		if (out_free) begin
			res_q.wide_i      <= wide_i_s2;
			res_q.wide_q      <= wide_q_s2;
			res_q.clip_i      <= clip_i_s2;
			res_q.clip_q      <= clip_q_s2;
			res_q.byte_sample <= byte_s2 ? sat8(rnd_q15(mix_full)) : '0;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

`ifndef SYNTHESIS
	// A closing request always leaves the running sums cleared.
	a_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && samples.data.last_channel |=> (sum_i_q == '0) && (sum_q_q == '0))
		else $error("running sums not cleared after the last channel");

	// The phasor only turns on a byte-mode closing request.
	a_phasor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && samples.data.last_channel && byte_mode_q)
		|=> $stable(phasor_cos_q) && $stable(phasor_sin_q))
		else $error("phasor changed without a byte-mode result");

	// A stalled stage-two result is not dropped.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(prod_i_s2) && $stable(wide_i_s2))
		else $error("stage two lost a result under stall");

	// Clip flags only come with a wide result, so the byte sample stays zero.
	a_clip_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.clip_i || res_q.clip_q) |-> res_q.byte_sample == '0)
		else $error("clip flag set on a byte-mode result");

	// Wide outputs stay inside the saturation limit.
	a_wide_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.wide_i <= SAMPLE_W'(32760)) && (res_q.wide_i >= -SAMPLE_W'(32760))
		&& (res_q.wide_q <= SAMPLE_W'(32760)) && (res_q.wide_q >= -SAMPLE_W'(32760)))
		else $error("wide result outside the saturation limit");
`endif

endmodule
